// ===== src/rbfl_pkg.sv =====
// shared types and constants for the receive byte fifo line reader
`timescale 1ns / 1ps
`default_nettype none

package rbfl_pkg;

  localparam int FIFO_DEPTH_DEF = 128;
  localparam logic [6:0] MAX_LINE = 7'd64;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
    logic [6:0] max_len;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [5:0] line_length;
    logic       is_last;
    logic [7:0] fill_count;
    logic       overflow;
  } out_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_POP,
    EMIT_LINE_BYTE,
    EMIT_TERM
  } emit_t;

  typedef struct packed {
    logic  do_push;
    logic  do_pop;
    logic  line_init;
    logic  stored_inc;
    logic  ovf;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic line_more;
    logic rd_zero;
    logic rd_newline;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/rbfl_ctrl.sv =====
// controller state machine for the receive byte fifo line reader
`timescale 1ns / 1ps
`default_nettype none

module rbfl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire rbfl_pkg::stat_t stat,
  output rbfl_pkg::cmd_t     cmd,
  output logic               busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_CHECK = 5'b00100,
    S_EVAL  = 5'b01000,
    S_END   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.emit       = rbfl_pkg::EMIT_NONE;
    busy           = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (mode)
            rbfl_pkg::MODE_PUSH: begin
              cmd.emit = rbfl_pkg::EMIT_STATUS;
              if (stat.full) begin
                cmd.ovf = 1'b1;
              end else begin
                cmd.do_push = 1'b1;
              end
            end
            rbfl_pkg::MODE_POP: begin
              if (stat.empty) begin
                cmd.emit = rbfl_pkg::EMIT_STATUS;
              end else begin
                state_next = S_POP;
              end
            end
            rbfl_pkg::MODE_LINE: begin
              cmd.line_init = 1'b1;
              state_next    = S_CHECK;
            end
            default: begin
              cmd.emit = rbfl_pkg::EMIT_STATUS;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.do_pop = 1'b1;
        cmd.emit   = rbfl_pkg::EMIT_POP;
        state_next = S_IDLE;
      end
      S_CHECK: begin
        if (stat.line_more && !stat.empty) begin
          state_next = S_EVAL;
        end else begin
          cmd.emit   = rbfl_pkg::EMIT_TERM;
          state_next = S_IDLE;
        end
      end
      S_EVAL: begin
        cmd.do_pop = 1'b1;
        if (stat.rd_zero) begin
          cmd.emit   = rbfl_pkg::EMIT_TERM;
          state_next = S_IDLE;
        end else begin
          cmd.emit       = rbfl_pkg::EMIT_LINE_BYTE;
          cmd.stored_inc = 1'b1;
          state_next     = stat.rd_newline ? S_END : S_CHECK;
        end
      end
      S_END: begin
        cmd.emit   = rbfl_pkg::EMIT_TERM;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rbfl_dp.sv =====
// datapath: byte memory, pointers, fill count, line counters and result register
`timescale 1ns / 1ps
`default_nettype none

module rbfl_dp #(
  parameter int FIFO_DEPTH = rbfl_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rbfl_pkg::in_t  item,
  input  wire rbfl_pkg::cmd_t cmd,
  output rbfl_pkg::stat_t     stat,
  output rbfl_pkg::out_t      result,
  output logic                result_valid
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] write_index;
  logic [AW-1:0] read_index;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [6:0]    lim;
  logic [5:0]    stored;

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[write_index] <= item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[read_index];
  end

  always_comb begin
    priority if (cmd.do_push) begin
      count_next = count + CW'(1);
    end else if (cmd.do_pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      count       <= '0;
    end else begin
      count <= count_next;
      if (cmd.do_push) begin
        write_index <= (write_index == LAST_IDX) ? '0 : write_index + AW'(1);
      end
      if (cmd.do_pop) begin
        read_index <= (read_index == LAST_IDX) ? '0 : read_index + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line_init) begin
      lim    <= (item.max_len > rbfl_pkg::MAX_LINE) ? rbfl_pkg::MAX_LINE : item.max_len;
      stored <= '0;
    end else if (cmd.stored_inc) begin
      stored <= stored + 6'd1;
    end
  end

  always_comb begin
    stat.full       = (count == CW'(FIFO_DEPTH));
    stat.empty      = (count == '0);
    stat.line_more  = ((7'(stored) + 7'd1) < lim);
    stat.rd_zero    = (rdata == 8'd0);
    stat.rd_newline = (rdata == rbfl_pkg::NEWLINE_BYTE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != rbfl_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    result.fill_count <= 8'(count_next);
    result.overflow   <= cmd.ovf;
    unique case (cmd.emit)
      rbfl_pkg::EMIT_POP: begin
        result.out_byte    <= rdata;
        result.byte_valid  <= 1'b1;
        result.line_length <= '0;
        result.is_last     <= 1'b1;
      end
      rbfl_pkg::EMIT_LINE_BYTE: begin
        result.out_byte    <= rdata;
        result.byte_valid  <= 1'b1;
        result.line_length <= '0;
        result.is_last     <= 1'b0;
      end
      rbfl_pkg::EMIT_TERM: begin
        result.out_byte    <= '0;
        result.byte_valid  <= 1'b0;
        result.line_length <= stored;
        result.is_last     <= 1'b1;
      end
      default: begin
        result.out_byte    <= '0;
        result.byte_valid  <= 1'b0;
        result.line_length <= '0;
        result.is_last     <= 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rx_byte_fifo_line_reader_top.sv =====
// top level of the receive byte fifo line reader
//
// command channel: start with item (mode, in_byte, max_len) is taken at a
// rising edge where start is high and busy is low.
// result channel: result_valid marks result for exactly one cycle; the
// receiver takes every beat and cannot stall the block.
// push, pop of an empty fifo and unknown modes: one result the cycle after
// the command, busy stays low, so a command may follow every cycle.
// a push into a full fifo drops the byte and sets overflow.
// pop of a non-empty fifo: busy while in state S_POP, which passes the
// byte to the result register; the byte memory has a registered read port.
// line read: each stored byte takes a check (S_CHECK) and then a memory
// read and evaluate step (S_EVAL), and a terminator beat follows; a line
// that ends on a zero byte also spends a check and a read on that byte,
// which is popped but not stored. the terminator carries the line length.
// every beat reports the fill count after it.
// reset (rst, synchronous) empties the fifo and returns to idle; memory
// contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rx_byte_fifo_line_reader_top #(
  parameter int FIFO_DEPTH = rbfl_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rbfl_pkg::in_t item,
  output logic               busy,
  output rbfl_pkg::out_t     result,
  output logic               result_valid
);

  rbfl_pkg::cmd_t  cmd;
  rbfl_pkg::stat_t stat;

  rbfl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (item.mode),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  rbfl_dp #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

`default_nettype wire

// ===== src/rbfl_checker.sv =====
// port-level checker for the receive byte fifo line reader, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rbfl_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire rbfl_pkg::out_t result,
  input wire logic           result_valid
);

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("accepted command neither answered nor in progress");

  a_mid_line_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.is_last) |-> (result.byte_valid && busy))
    else $error("non-final beat is not a line byte");

  a_idle_beat_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !busy) |-> result.is_last)
    else $error("beat while idle is not final");

  a_overflow_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.overflow) |->
      (result.is_last && !result.byte_valid && result.line_length == 6'd0))
    else $error("overflow beat malformed");

endmodule

bind rx_byte_fifo_line_reader_top rbfl_checker u_rbfl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result      (result),
  .result_valid(result_valid)
);

`default_nettype wire

// ===== bench/rx_byte_fifo_line_reader_top_tb.sv =====
// self-checking testbench for the receive byte fifo line reader top level
`timescale 1ns / 1ps

module rx_byte_fifo_line_reader_top_tb;

  localparam int DEPTH = rbfl_pkg::FIFO_DEPTH_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rbfl_pkg::in_t item = '0;
  logic busy;
  rbfl_pkg::out_t result;
  logic result_valid;

  logic [7:0] fifo_mem [DEPTH];
  int fifo_wr = 0;
  int fifo_rd = 0;
  int fifo_cnt = 0;
  rbfl_pkg::out_t beats_due [$];
  int mismatches = 0;
  bit no_gaps = 1'b0;

  rx_byte_fifo_line_reader_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result(result),
    .result_valid(result_valid)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rbfl_pkg::in_t cmd_of(logic [1:0] mode, logic [7:0] data,
                                           logic [6:0] len);
    rbfl_pkg::in_t c;
    c.mode = mode;
    c.in_byte = data;
    c.max_len = len;
    return c;
  endfunction

  function automatic logic [7:0] fifo_take();
    logic [7:0] d;
    d = fifo_mem[fifo_rd];
    fifo_rd = (fifo_rd + 1) % DEPTH;
    fifo_cnt--;
    return d;
  endfunction

  function automatic void predict_beats(rbfl_pkg::in_t cmd);
    rbfl_pkg::out_t b;
    rbfl_pkg::out_t lb;
    logic [6:0] lim;
    logic [7:0] d;
    int stored;
    bit done;
    b = '0;
    stored = 0;
    done = 1'b0;
    case (cmd.mode)
      rbfl_pkg::MODE_PUSH: begin
        if (fifo_cnt < DEPTH) begin
          fifo_mem[fifo_wr] = cmd.in_byte;
          fifo_wr = (fifo_wr + 1) % DEPTH;
          fifo_cnt++;
        end else begin
          b.overflow = 1'b1;
        end
      end
      rbfl_pkg::MODE_POP: begin
        if (fifo_cnt > 0) begin
          b.out_byte = fifo_take();
          b.byte_valid = 1'b1;
        end
      end
      rbfl_pkg::MODE_LINE: begin
        lim = (cmd.max_len > rbfl_pkg::MAX_LINE) ? rbfl_pkg::MAX_LINE : cmd.max_len;
        while (!done && lim > 0 && stored < int'(lim) - 1 && fifo_cnt > 0) begin
          d = fifo_take();
          if (d == 8'h00) begin
            done = 1'b1;
          end else begin
            lb = '0;
            lb.out_byte = d;
            lb.byte_valid = 1'b1;
            lb.fill_count = 8'(fifo_cnt);
            beats_due.push_back(lb);
            stored++;
            if (d == rbfl_pkg::NEWLINE_BYTE) done = 1'b1;
          end
        end
        b.line_length = 6'(stored);
      end
      default: ;
    endcase
    b.is_last = 1'b1;
    b.fill_count = 8'(fifo_cnt);
    beats_due.push_back(b);
  endfunction

  function automatic string beat_text(rbfl_pkg::out_t b);
    return $sformatf("byte=%02h valid=%0b len=%0d last=%0b fill=%0d ovf=%0b",
                     b.out_byte, b.byte_valid, b.line_length, b.is_last,
                     b.fill_count, b.overflow);
  endfunction

  always @(posedge clk) begin : beat_check
    rbfl_pkg::out_t want;
    if (!rst && result_valid) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected beat at %0t: %s", $time, beat_text(result));
      end else begin
        want = beats_due.pop_front();
        if (result.out_byte !== want.out_byte || result.byte_valid !== want.byte_valid ||
            result.line_length !== want.line_length || result.is_last !== want.is_last ||
            result.fill_count !== want.fill_count || result.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("beat mismatch at %0t: expected %s, got %s", $time,
                     beat_text(want), beat_text(result));
        end
      end
    end
  end

  task automatic issue_cmd(input rbfl_pkg::in_t cmd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predict_beats(cmd);
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r < 3) return rbfl_pkg::NEWLINE_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] rand_len();
    if ($urandom_range(0, 4) < 3) return 7'($urandom_range(0, 16));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic test_empty_fifo();
    issue_cmd(cmd_of(rbfl_pkg::MODE_POP, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'hFF, 7'd64));
    issue_cmd(cmd_of(MODE_SPARE, 8'hFF, 7'd127));
  endtask

  task automatic test_push_pop();
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h00, 7'd127));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'hFF, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, rbfl_pkg::NEWLINE_BYTE, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h55, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'hAA, 7'd0));
    repeat (6) issue_cmd(cmd_of(rbfl_pkg::MODE_POP, 8'hFF, 7'd127));
  endtask

  task automatic test_line_ends();
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h61, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h62, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, rbfl_pkg::NEWLINE_BYTE, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h63, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h64, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h65, 7'd0));
    issue_cmd(cmd_of(MODE_SPARE, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd1));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd127));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd2));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd64));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd3));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd5));
  endtask

  task automatic test_full_fifo();
    logic [7:0] d;
    no_gaps = 1'b1;
    while (fifo_cnt < DEPTH) begin
      d = 8'($urandom_range(1, 255));
      if (d == rbfl_pkg::NEWLINE_BYTE) d = 8'h0B;
      issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, d, 7'd0));
    end
    no_gaps = 1'b0;
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'hFF, 7'd127));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_POP, 8'h00, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, rbfl_pkg::NEWLINE_BYTE, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, 8'h5A, 7'd0));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd127));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd64));
    issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'h00, 7'd65));
    while (fifo_cnt > 0)
      issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, 8'($urandom), 7'($urandom_range(0, 127))));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int k;
    sent = 0;
    while (sent < n_items) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        burst = $urandom_range(0, 16);
        for (k = 0; k < burst; k++) begin
          if (k == burst - 1 && $urandom_range(0, 1) == 1)
            issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, rbfl_pkg::NEWLINE_BYTE, rand_len()));
          else
            issue_cmd(cmd_of(rbfl_pkg::MODE_PUSH, rand_byte(), rand_len()));
        end
        issue_cmd(cmd_of(rbfl_pkg::MODE_LINE, rand_byte(), rand_len()));
        sent += burst + 1;
        if ($urandom_range(0, 2) == 0) begin
          issue_cmd(cmd_of(rbfl_pkg::MODE_POP, rand_byte(), rand_len()));
          sent++;
        end
      end else begin
        issue_cmd(cmd_of(2'($urandom_range(0, 3)), rand_byte(), rand_len()));
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_fifo();
    test_push_pop();
    test_line_ends();
    test_full_fifo();
    test_random_traffic(130);
    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
